// ===== rtl/assert_macros.svh =====
// assertion macros included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define TSCD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define TSCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tscd_pkg.sv =====
// types, constants and the crc step for the scratchpad crc decoder
package tscd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned TEMP_W = 12;
  localparam int unsigned RES_W  = 4;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned MAG_W  = 11;

  // request function codes
  localparam logic FUNC_DATA  = 1'b0;
  localparam logic FUNC_ABORT = 1'b1;

  // scratchpad byte positions of interest
  localparam logic [POS_W-1:0] POS_TEMP_LOW  = 4'd0;
  localparam logic [POS_W-1:0] POS_TEMP_HIGH = 4'd1;
  localparam logic [POS_W-1:0] POS_CONFIG    = 4'd4;
  localparam logic [POS_W-1:0] POS_CRC       = 4'd8;

  localparam logic [BYTE_W-1:0] CRC_POLY         = 8'h8C;
  localparam logic [BYTE_W-1:0] BYTE_RESET       = 8'hFF;
  localparam logic [BYTE_W-1:0] THRESHOLD_RESET  = 8'd5;
  localparam logic [RES_W-1:0]  RES_BASE         = 4'd9;

  // resolution codes from config bits 6:5
  localparam logic [1:0] RES_CODE_9  = 2'd0;
  localparam logic [1:0] RES_CODE_10 = 2'd1;
  localparam logic [1:0] RES_CODE_11 = 2'd2;
  localparam logic [1:0] RES_CODE_12 = 2'd3;

  // result payload held in the output register
  typedef struct packed {
    logic                     crc_ok;
    logic signed [TEMP_W-1:0] temperature;
    logic [RES_W-1:0]         resolution_bits;
    logic [BYTE_W-1:0]        mismatch_count;
    logic                     malfunction;
  } tscd_result_t;

  // reflected crc-8, one byte, eight unrolled bit steps
  function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] data_in);
    logic [BYTE_W-1:0] crc;
    logic [BYTE_W-1:0] b;
    logic              mix;
    crc = crc_in;
    b   = data_in;
    for (int i = 0; i < BYTE_W; i++) begin
      mix = crc[0] ^ b[0];
      crc = crc >> 1;
      if (mix) begin
        crc = crc ^ CRC_POLY;
      end
      b = b >> 1;
    end
    return crc;
  endfunction

endpackage

// ===== rtl/tscd_ifs.sv =====
// valid/ready channel interfaces for bytes, results and configuration
interface tscd_byte_if import tscd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, func, data_byte, input ready);
  modport sink   (input valid, func, data_byte, output ready);
endinterface

interface tscd_result_if import tscd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     crc_ok;
  logic signed [TEMP_W-1:0] temperature;
  logic [RES_W-1:0]         resolution_bits;
  logic [BYTE_W-1:0]        mismatch_count;
  logic                     malfunction;

  modport source (output valid, crc_ok, temperature, resolution_bits, mismatch_count,
                  malfunction, input ready);
  modport sink   (input valid, crc_ok, temperature, resolution_bits, mismatch_count,
                  malfunction, output ready);
endinterface

interface tscd_cfg_if import tscd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/temp_scratchpad_crc_decode.sv =====
// scratchpad crc check and temperature decode, top level
// a byte request is captured in the input register; a ninth byte then fills the result register
// throughput: one byte request per cycle; input stalls only while a result waits untaken
// bytes that close no frame and abort requests pass without waiting on the result side
// reset (rst, synchronous): threshold 5, captured bytes 0xff, count, flags and held values 0
module temp_scratchpad_crc_decode import tscd_pkg::*; (
  input logic        clk,
  input logic        rst,
  tscd_cfg_if.sink   cfg_chan,
  tscd_byte_if.sink  byte_chan,
  tscd_result_if.source result_chan
);

`include "assert_macros.svh"

  // input register
  logic              s1_valid;
  logic              s1_func;
  logic [BYTE_W-1:0] s1_byte;

  // frame and hold state
  logic [BYTE_W-1:0] threshold;
  logic [POS_W-1:0]  byte_position;
  logic [BYTE_W-1:0] crc_acc;
  logic [BYTE_W-1:0] temp_low;
  logic [BYTE_W-1:0] temp_high;
  logic [BYTE_W-1:0] config_byte;
  logic [BYTE_W-1:0] mismatch_count;
  logic              malfunction;
  logic signed [TEMP_W-1:0] held_temp;
  logic [RES_W-1:0]  held_res;

  // result register
  logic              out_valid;
  tscd_result_t      out_data;

  logic              out_free;
  logic              s1_result;
  logic              s1_adv;
  logic              s1_fire;
  logic              in_ready;
  logic              crc_ok;
  logic [BYTE_W-1:0] count_next;
  logic              malfunction_next;
  logic signed [TEMP_W-1:0] dec_temp;
  logic [RES_W-1:0]  dec_res;

  // configuration port, always ready
  assign cfg_chan.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg_chan.valid) begin
      threshold <= cfg_chan.data;
    end
  end

  // handshake: only a frame-closing byte needs the result register
  assign out_free  = !out_valid || result_chan.ready;
  assign s1_result = s1_valid && (s1_func == FUNC_DATA) && (byte_position == POS_CRC);
  assign s1_adv    = !s1_result || out_free;
  assign s1_fire   = s1_valid && s1_adv;
  assign in_ready  = !s1_valid || s1_adv;
  assign byte_chan.ready = in_ready;

  // input register capture
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= byte_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && byte_chan.valid) begin
      s1_func <= byte_chan.func;
      s1_byte <= byte_chan.data_byte;
    end
  end

  // decode from captured bytes
  tscd_decode u_decode (
    .temp_low    (temp_low),
    .temp_high   (temp_high),
    .config_in   (config_byte),
    .temperature (dec_temp),
    .resolution  (dec_res)
  );

  // crc compare and saturating mismatch count
  assign crc_ok = (crc_acc == s1_byte);
  always_comb begin
    if (crc_ok) begin
      count_next = '0;
    end else if (mismatch_count < threshold) begin
      count_next = mismatch_count + 8'd1;
    end else begin
      count_next = threshold;
    end
    malfunction_next = malfunction || (!crc_ok && (count_next >= threshold));
  end

  // frame state update
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      crc_acc        <= '0;
      temp_low       <= BYTE_RESET;
      temp_high      <= BYTE_RESET;
      config_byte    <= BYTE_RESET;
      mismatch_count <= '0;
      malfunction    <= 1'b0;
      held_temp      <= '0;
      held_res       <= '0;
    end else if (s1_fire) begin
      if (s1_func == FUNC_ABORT) begin
        byte_position  <= '0;
        crc_acc        <= '0;
        mismatch_count <= '0;
      end else if (byte_position != POS_CRC) begin
        if (byte_position == POS_TEMP_LOW) begin
          temp_low <= s1_byte;
        end
        if (byte_position == POS_TEMP_HIGH) begin
          temp_high <= s1_byte;
        end
        if (byte_position == POS_CONFIG) begin
          config_byte <= s1_byte;
        end
        crc_acc       <= crc8_byte(crc_acc, s1_byte);
        byte_position <= byte_position + 4'd1;
      end else begin
        byte_position  <= '0;
        crc_acc        <= '0;
        mismatch_count <= count_next;
        malfunction    <= malfunction_next;
        if (crc_ok) begin
          held_temp <= dec_temp;
          held_res  <= dec_res;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_result) begin
      out_valid <= 1'b1;
    end else if (result_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_result) begin
      out_data.crc_ok          <= crc_ok;
      out_data.temperature     <= crc_ok ? dec_temp : held_temp;
      out_data.resolution_bits <= crc_ok ? dec_res : held_res;
      out_data.mismatch_count  <= count_next;
      out_data.malfunction     <= malfunction_next;
    end
  end

  assign result_chan.valid           = out_valid;
  assign result_chan.crc_ok          = out_data.crc_ok;
  assign result_chan.temperature     = out_data.temperature;
  assign result_chan.resolution_bits = out_data.resolution_bits;
  assign result_chan.mismatch_count  = out_data.mismatch_count;
  assign result_chan.malfunction     = out_data.malfunction;

  // checks
  `TSCD_ASSERT_IMPL(a_pos_range, 1'b1, byte_position <= POS_CRC, "byte position past crc byte")
  `TSCD_ASSERT_IMPL(a_ok_clears_count, out_valid && out_data.crc_ok,
                    out_data.mismatch_count == '0, "crc match with nonzero mismatch count")
  `TSCD_ASSERT_NEXT(a_stall_holds, s1_valid && !s1_adv,
                    s1_valid && $stable(s1_byte) && $stable(byte_position),
                    "stalled closing byte lost")
  `TSCD_ASSERT_NEXT(a_malfunction_sticky, malfunction, malfunction,
                    "malfunction flag cleared without reset")

endmodule

// ===== rtl/tscd_decode.sv =====
// temperature and resolution decode from the captured scratchpad bytes
module tscd_decode import tscd_pkg::*; (
  input  logic [BYTE_W-1:0]        temp_low,
  input  logic [BYTE_W-1:0]        temp_high,
  input  logic [BYTE_W-1:0]        config_in,
  output logic signed [TEMP_W-1:0] temperature,
  output logic [RES_W-1:0]         resolution
);

  logic [2*BYTE_W-1:0] word;
  logic [2*BYTE_W-1:0] word_abs;
  logic                negative;
  logic [1:0]          res_code;
  logic [3:0]          frac_mask;
  logic [MAG_W-1:0]    mag;
  logic [TEMP_W-1:0]   mag_ext;

  // sign-magnitude of the raw word
  assign word     = {temp_high, temp_low};
  assign negative = word[2*BYTE_W-1];
  assign word_abs = negative ? (~word + 16'd1) : word;

  // fraction bits kept by the resolution
  assign res_code = config_in[6:5];
  always_comb begin
    unique case (res_code)
      RES_CODE_9:  frac_mask = 4'b1000;
      RES_CODE_10: frac_mask = 4'b1100;
      RES_CODE_11: frac_mask = 4'b1110;
      RES_CODE_12: frac_mask = 4'b1111;
      default:     frac_mask = 4'b1111;
    endcase
  end

  // 7-bit integer part over masked fraction, then reapply sign
  assign mag         = {word_abs[10:4], word_abs[3:0] & frac_mask};
  assign mag_ext     = {1'b0, mag};
  assign temperature = negative ? signed'(-mag_ext) : signed'(mag_ext);
  assign resolution  = RES_BASE + {2'b00, res_code};

endmodule
